/* rtl/dds_pkg.sv */
// Shared types, widths and codes for the discrete distribution sampler.
package dds_pkg;

  // Default parameter values.
  localparam int MaxEntriesDef = 256;
  localparam int WeightBitsDef = 16;
  localparam int RandomBitsDef = 16;

  // Fixed field and table widths.
  localparam int WeightW = 16;
  localparam int RandomW = 16;
  localparam int IndexW  = 8;
  localparam int TotalW  = 24;
  localparam int TargetW = RandomW + TotalW;

  // Saturation value of the running total.
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Opcode of an input word.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;   // latch the accepted input word
    logic       load;      // append the captured weight to the table
    logic       mul_init;  // form the search target and the search bounds
    logic       read;      // read the table at the search midpoint
    logic       step;      // compare the read entry and narrow the bounds
    logic       emit;      // put a result word on the output
    logic [1:0] code;      // status of the emitted result
  } dds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sample;    // captured word is a sample request
    logic full;         // a load would not fit in the table
    logic empty;        // no entries or a zero total
    logic search_done;  // the search bounds have met
  } dds_stat_t;

endpackage

/* rtl/dds_ctrl.sv */
// Controller state machine of the discrete distribution sampler.
module dds_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dds_pkg::dds_stat_t stat,
  output dds_pkg::dds_cmd_t  cmd
);
  import dds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_DECODE  = 4'b0010,
    S_SEARCH  = 4'b0100,
    S_COMPARE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.code     = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_sample) begin
          if (stat.full) begin
            cmd.emit = 1'b1;
            cmd.code = ST_FULL;
          end else begin
            cmd.load = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (stat.empty) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          cmd.mul_init = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          cmd.read  = 1'b1;
          state_nxt = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.step  = 1'b1;
        state_nxt = S_SEARCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dds_dpath.sv */
// Datapath of the discrete distribution sampler: table memory, totals and search.
module dds_dpath #(
  parameter int MAX_ENTRIES = dds_pkg::MaxEntriesDef,
  parameter int WEIGHT_BITS = dds_pkg::WeightBitsDef,
  parameter int RANDOM_BITS = dds_pkg::RandomBitsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dds_pkg::dds_cmd_t          cmd,
  output dds_pkg::dds_stat_t         stat,
  input  logic                       in_opcode,
  input  logic [dds_pkg::WeightW-1:0] in_weight,
  input  logic                       in_start_new,
  input  logic [dds_pkg::RandomW-1:0] in_random_value,
  output logic                       out_valid,
  output logic [dds_pkg::IndexW-1:0] out_sample_index,
  output logic [1:0]                 out_status
);
  import dds_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int W_SH  = (WEIGHT_BITS >= WeightW) ? WeightW : WEIGHT_BITS;
  localparam int R_SH  = (RANDOM_BITS >= RandomW) ? RandomW : RANDOM_BITS;
  localparam logic [WeightW-1:0] W_MASK =
    WeightW'(((WeightW+1)'(1) << W_SH) - (WeightW+1)'(1));
  localparam logic [RandomW-1:0] R_MASK =
    RandomW'(((RandomW+1)'(1) << R_SH) - (RandomW+1)'(1));
  localparam int CMP_W = (TotalW + RANDOM_BITS > TargetW) ? TotalW + RANDOM_BITS : TargetW;

  // Cumulative table memory.
  logic [TotalW-1:0] mem [MAX_ENTRIES];
  logic [TotalW-1:0] rdata_r;

  // Distribution state.
  logic [CNT_W-1:0]  cnt_r;
  logic [TotalW-1:0] total_r;

  // Captured input word.
  logic               op_r;
  logic [WeightW-1:0] weight_r;
  logic               new_r;
  logic [RandomW-1:0] rand_r;

  // Search state.
  logic [TargetW-1:0] target_r;
  logic [IDX_W-1:0]   lo_r;
  logic [IDX_W-1:0]   hi_r;

  // Output register.
  logic              out_valid_r;
  logic [IndexW-1:0] out_index_r;
  logic [1:0]        out_status_r;

  logic [CNT_W-1:0]    eff_cnt;
  logic [TotalW-1:0]   eff_total;
  logic [TotalW:0]     sum_wide;
  logic [TotalW-1:0]   sum_sat;
  logic [IDX_W:0]      mid_wide;
  logic [IDX_W-1:0]    mid;
  logic [CMP_W-1:0]    cmp_lhs;
  logic [CMP_W-1:0]    cmp_rhs;
  logic [IDX_W+IndexW-1:0] lo_ext;

  // A load with start_new sees an empty table.
  assign eff_cnt   = new_r ? '0 : cnt_r;
  assign eff_total = new_r ? '0 : total_r;

  // Saturating cumulative sum for the next entry.
  assign sum_wide = {1'b0, eff_total} + (TotalW+1)'(weight_r);
  assign sum_sat  = sum_wide[TotalW] ? TotalMax : sum_wide[TotalW-1:0];

  // Search midpoint and comparison of the scaled entry against the target.
  assign mid_wide = ({1'b0, lo_r} + {1'b0, hi_r}) >> 1;
  assign mid      = mid_wide[IDX_W-1:0];
  assign cmp_lhs  = CMP_W'(rdata_r) << RANDOM_BITS;
  assign cmp_rhs  = CMP_W'(target_r);
  assign lo_ext   = {{IndexW{1'b0}}, lo_r};

  // Status to the controller.
  assign stat.is_sample   = (op_r == OP_SAMPLE);
  assign stat.full        = (eff_cnt >= CNT_W'(MAX_ENTRIES));
  assign stat.empty       = (cnt_r == '0) || (total_r == '0);
  assign stat.search_done = (lo_r >= hi_r);

  // Table write on load and registered read during the search.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[eff_cnt[IDX_W-1:0]] <= sum_sat;
    end
    if (cmd.read) begin
      rdata_r <= mem[mid];
    end
  end

  // Entry count and running total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
    end else if (cmd.load) begin
      cnt_r   <= eff_cnt + CNT_W'(1);
      total_r <= sum_sat;
    end
  end

  // Input capture, target multiply and bound updates.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_opcode;
      weight_r <= in_weight & W_MASK;
      new_r    <= in_start_new;
      rand_r   <= in_random_value & R_MASK;
    end
    if (cmd.mul_init) begin
      target_r <= TargetW'(rand_r) * TargetW'(total_r);
      lo_r     <= '0;
      hi_r     <= IDX_W'(cnt_r - CNT_W'(1));
    end else if (cmd.step) begin
      if (cmp_lhs > cmp_rhs) begin
        hi_r <= mid;
      end else begin
        lo_r <= IDX_W'(mid_wide + (IDX_W+1)'(1));
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      out_index_r  <= (cmd.code == ST_OK) ? lo_ext[IndexW-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_index = out_index_r;
  assign out_status       = out_status_r;

endmodule

/* rtl/discrete_distribution_sampler_core.sv */
// Top level of the discrete distribution sampler.
// Usage: a word is accepted when start is high and busy is low. in_opcode
// selects a load (append in_weight to the cumulative table, in_start_new
// first empties it) or a sample (draw an index using in_random_value).
// Results appear on out_sample_index and out_status for one cycle with
// out_valid high; the receiver cannot stall, so every result must be taken.
// A successful load gives no result and holds busy only in S_DECODE; the next
// word is accepted after busy falls. A load into a full table or a sample of an
// empty or zero-total distribution gives one result, decided in S_DECODE and
// registered on the output, with busy low again by then.
// A sample runs a binary search over the table: setup in S_DECODE for the
// target multiply, then for each halving step the registered memory read in
// S_SEARCH and the compare in S_COMPARE, then a last S_SEARCH that finishes;
// the result strobe rises at the same edge at which busy falls. One word is
// worked on at a time. Reset clears the entry count, the running total, the
// output strobe and the controller; the table memory itself is not cleared
// and is read only below the entry count.
module discrete_distribution_sampler_core #(
  parameter int MAX_ENTRIES = dds_pkg::MaxEntriesDef,
  parameter int WEIGHT_BITS = dds_pkg::WeightBitsDef,
  parameter int RANDOM_BITS = dds_pkg::RandomBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [dds_pkg::WeightW-1:0] in_weight,
  input  logic                        in_start_new,
  input  logic [dds_pkg::RandomW-1:0] in_random_value,
  output logic                        out_valid,
  output logic [dds_pkg::IndexW-1:0]  out_sample_index,
  output logic [1:0]                  out_status
);
  import dds_pkg::*;

  dds_cmd_t  cmd;
  dds_stat_t stat;

  // Controller.
  dds_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath.
  dds_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_weight        (in_weight),
    .in_start_new     (in_start_new),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_sample_index (out_sample_index),
    .out_status       (out_status)
  );

endmodule

/* tb/tb_discrete_distribution_sampler_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the discrete distribution sampler core.
module tb_discrete_distribution_sampler_core;
  import dds_pkg::*;

  localparam int ItemsTarget   = 1150;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 40;
  localparam int SumW          = TotalW + 1;

  // One result word: chosen index and status.
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [1:0]        status;
  } draw_result_t;

  // Scoreboard: tracks the cumulative table and queues the expected draws.
  class sampler_scoreboard;
    logic [TotalW-1:0] cum_table [MaxEntriesDef];
    int unsigned       entry_count;
    logic [TotalW-1:0] total;
    draw_result_t      expected_draws [$];
    int                errors;

    function new();
      entry_count = 0;
      total = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) begin
        $display("MISMATCH at %0t: %s", $time, what);
      end
    endtask

    // Update the table for an accepted word and queue the result it causes.
    function void note_word(logic op, logic [WeightW-1:0] w, logic sn,
                            logic [RandomW-1:0] rv);
      draw_result_t       res;
      logic [SumW-1:0]    sum;
      logic [TargetW-1:0] target;
      int                 pick;
      res = '0;
      if (op == OP_LOAD) begin
        if (sn) begin
          entry_count = 0;
          total = '0;
        end
        if (entry_count >= MaxEntriesDef) begin
          res.status = ST_FULL;
          expected_draws.push_back(res);
        end else begin
          // The running total saturates instead of wrapping.
          sum = {1'b0, total} + SumW'(w);
          total = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
          cum_table[entry_count] = total;
          entry_count++;
        end
      end else if (entry_count == 0 || total == '0) begin
        res.status = ST_EMPTY;
        expected_draws.push_back(res);
      end else begin
        // First entry whose scaled cumulative sum exceeds r times the total.
        target = TargetW'(rv) * TargetW'(total);
        pick = int'(entry_count) - 1;
        for (int i = int'(entry_count) - 1; i >= 0; i--) begin
          if ((TargetW'(cum_table[i]) << RandomBitsDef) > target) pick = i;
        end
        res.index = pick[IndexW-1:0];
        res.status = ST_OK;
        expected_draws.push_back(res);
      end
    endfunction

    // Compare a result word with the oldest expectation.
    task check_result(logic [IndexW-1:0] idx, logic [1:0] st);
      draw_result_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d status %0d", idx, st));
      end else begin
        want = expected_draws.pop_front();
        if (idx !== want.index) begin
          report_mismatch($sformatf("index %0d, expected %0d", idx, want.index));
        end
        if (st !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        end
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_opcode;
  logic [WeightW-1:0] in_weight;
  logic               in_start_new;
  logic [RandomW-1:0] in_random_value;
  logic               out_valid;
  logic [IndexW-1:0]  out_sample_index;
  logic [1:0]         out_status;

  sampler_scoreboard sb = new();
  int                n_sent;
  int                stall_cycles;

  discrete_distribution_sampler_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_weight        (in_weight),
    .in_start_new     (in_start_new),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_sample_index (out_sample_index),
    .out_status       (out_status)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record each accepted word and check each result word.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_word(in_opcode, in_weight, in_start_new, in_random_value);
    end
    if (rst_n && out_valid) begin
      sb.check_result(out_sample_index, out_status);
    end
  end

  // Stop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Weights favor zero, full scale and small values.
  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return WeightW'($urandom_range(0, 15));
      default: return WeightW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [RandomW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return RandomW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Present one word and hold it until the core takes it, then maybe idle.
  task automatic send_word(input logic op, input logic [WeightW-1:0] w,
                           input logic sn, input logic [RandomW-1:0] rv);
    int idle_pct;
    in_opcode       <= op;
    in_weight       <= w;
    in_start_new    <= sn;
    in_random_value <= rv;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    n_sent++;
    idle_pct = (n_sent < ItemsTarget / 3) ? 18 : (n_sent < 2 * ItemsTarget / 3) ? 70 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  // Mostly complete distributions followed by draws, some noise, two full fills.
  task automatic run_random();
    int size;
    int kind;
    int fills;
    bit zero_run;
    fills = 0;
    while (n_sent < ItemsTarget) begin
      kind = $urandom_range(0, 99);
      if (fills < 2 && n_sent >= 250 + fills * 400) begin
        // Fill the table, overflow it, then draw across all entries.
        send_word(OP_LOAD, rand_weight(), 1'b1, rand_value());
        for (int k = 1; k < MaxEntriesDef; k++) begin
          send_word(OP_LOAD, rand_weight(), 1'b0, rand_value());
        end
        repeat ($urandom_range(1, 3)) send_word(OP_LOAD, rand_weight(), 1'b0, rand_value());
        repeat ($urandom_range(4, 8)) begin
          send_word(OP_SAMPLE, rand_weight(), 1'($urandom_range(0, 1)), rand_value());
        end
        fills++;
      end else if (kind < 80) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        zero_run = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < size; k++) begin
          send_word(OP_LOAD, zero_run ? '0 : rand_weight(), k == 0, rand_value());
        end
        repeat ($urandom_range(1, 6)) begin
          send_word(OP_SAMPLE, rand_weight(), 1'($urandom_range(0, 1)), rand_value());
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_word(1'($urandom_range(0, 1)), rand_weight(), 1'($urandom_range(0, 1)),
                    rand_value());
        end
      end
    end
  endtask

  // Reset, directed cases, random traffic, then drain and report.
  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_LOAD;
    in_weight       = '0;
    in_start_new    = 1'b0;
    in_random_value = '0;
    n_sent          = 0;
    stall_cycles    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Draws from the empty table right after reset; start_new on a draw is ignored.
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'h0000);
    send_word(OP_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF);
    // Entries that all weigh zero give a zero total.
    send_word(OP_LOAD, 16'h0000, 1'b1, 16'h0000);
    send_word(OP_LOAD, 16'h0000, 1'b0, 16'hFFFF);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'h1234);
    // Extreme weights and extreme draw values.
    send_word(OP_LOAD, 16'hFFFF, 1'b1, 16'h0000);
    send_word(OP_LOAD, 16'h0000, 1'b0, 16'h0000);
    send_word(OP_LOAD, 16'h0001, 1'b0, 16'h0000);
    send_word(OP_LOAD, 16'hFFFF, 1'b0, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'hFFFF);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'h8000);
    send_word(OP_SAMPLE, 16'hFFFF, 1'b1, 16'h7FFF);
    // A single entry always wins.
    send_word(OP_LOAD, 16'h0005, 1'b1, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'hFFFF);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'h0000);
    // A leading zero-weight entry is never chosen.
    send_word(OP_LOAD, 16'h0000, 1'b1, 16'h0000);
    send_word(OP_LOAD, 16'h0001, 1'b0, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000, 1'b0, 16'h0000);

    run_random();
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dds_pkg.sv
rtl/dds_ctrl.sv
rtl/dds_dpath.sv
rtl/discrete_distribution_sampler_core.sv
tb/tb_discrete_distribution_sampler_core.sv
